// ----- rtl/hc2s_pkg.sv -----
`default_nettype none

package hc2s_pkg;

   localparam int LETTER_MOD = 26;

   localparam logic [4:0] KEY_TL_RESET = 5'd3;
   localparam logic [4:0] KEY_TR_RESET = 5'd3;
   localparam logic [4:0] KEY_BL_RESET = 5'd2;
   localparam logic [4:0] KEY_BR_RESET = 5'd5;

   localparam logic [2:0] CSR_KEY_TL   = 3'd0;
   localparam logic [2:0] CSR_KEY_TR   = 3'd1;
   localparam logic [2:0] CSR_KEY_BL   = 3'd2;
   localparam logic [2:0] CSR_KEY_BR   = 3'd3;
   localparam logic [2:0] CSR_DECRYPT  = 3'd4;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [6:0] CHAR_BASE     = 7'h41;
   localparam logic [4:0] PAD_LETTER    = 5'd23;  // 'X'

   typedef struct packed {
      logic [6:0] cipher_char;
      logic       last_in_run;
      logic       end_of_text;
      logic       key_error;
   } rsp_word_type;

   // x mod 26 for x < 2048: reciprocal estimate is low by at most one
   function automatic logic [4:0] mod26(input logic [10:0] x);
      logic [22:0] prod;
      logic [6:0]  q;
      logic [10:0] r;
      prod = 23'(x) * 23'd2520;
      q    = prod[22:16];
      r    = x - 11'(q) * 11'(LETTER_MOD);
      if (r >= 11'(LETTER_MOD)) begin
         r = r - 11'(LETTER_MOD);
      end
      return r[4:0];
   endfunction

   function automatic logic [4:0] unit_inverse(input logic [4:0] d);
      logic [4:0] inv;
      unique case (d)
         5'd1:    inv = 5'd1;
         5'd3:    inv = 5'd9;
         5'd5:    inv = 5'd21;
         5'd7:    inv = 5'd15;
         5'd9:    inv = 5'd3;
         5'd11:   inv = 5'd19;
         5'd15:   inv = 5'd7;
         5'd17:   inv = 5'd23;
         5'd19:   inv = 5'd11;
         5'd21:   inv = 5'd5;
         5'd23:   inv = 5'd17;
         5'd25:   inv = 5'd25;
         default: inv = 5'd0;
      endcase
      return inv;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hill_cipher_2x2_stream_top.sv -----
// Hill cipher, 2x2 key mod 26, on a byte stream.
// Input channel (req_): one ASCII byte per word plus a final flag. Non-letters
// are dropped, lower case is folded. Every second letter yields two cipher
// words on the output channel (rsp_); a final byte pads an unpaired letter with X.
// With a bad key (entry above 25 or determinant not a unit mod 26) each input
// word yields one error word with cipher_char 0.
// Configuration: csr_write_enable, csr_index (0..4: four key entries, then
// decrypt mode), csr_write_data; write only while the block is idle.
// Path: an accepted input word passes the pairing stage and the matrix stage
// into the output register, from which the receiver takes it.
// Throughput: one input word per cycle while words are dropped or held and the
// pairing stage is free; a completed pair leaves as two words on the single-word output channel.
// Reset clears the key to its default, encrypt mode, the held letter and all
// pipeline valids. When rsp_stall is high the output word holds, the stages
// behind it fill and req_stall rises once the input register cannot advance.
`default_nettype none

module hill_cipher_2x2_stream_top
   import hc2s_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [4:0] csr_write_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_cipher_char,
   output logic            rsp_last_in_run,
   output logic            rsp_end_of_text,
   output logic            rsp_key_error
);

   // configuration
   logic [4:0] key_tl_ff, key_tr_ff, key_bl_ff, key_br_ff;
   logic       decrypt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_tl_ff  <= KEY_TL_RESET;
         key_tr_ff  <= KEY_TR_RESET;
         key_bl_ff  <= KEY_BL_RESET;
         key_br_ff  <= KEY_BR_RESET;
         decrypt_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_TL:  key_tl_ff  <= csr_write_data;
            CSR_KEY_TR:  key_tr_ff  <= csr_write_data;
            CSR_KEY_BL:  key_bl_ff  <= csr_write_data;
            CSR_KEY_BR:  key_br_ff  <= csr_write_data;
            CSR_DECRYPT: decrypt_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // derived key: determinant and validity, then working matrix
   logic [4:0] det_in, det_ff;
   logic       key_valid_in, key_valid_ff;
   logic [4:0] prod_a, prod_b;
   logic [5:0] det_sum;

   always_comb begin
      prod_a  = mod26(11'(key_tl_ff) * 11'(key_br_ff));
      prod_b  = mod26(11'(key_tr_ff) * 11'(key_bl_ff));
      det_sum = 6'(prod_a) + 6'(LETTER_MOD) - 6'(prod_b);
      det_in  = (det_sum >= 6'(LETTER_MOD)) ? 5'(det_sum - 6'(LETTER_MOD)) : det_sum[4:0];
      key_valid_in = (key_tl_ff <= 5'd25) && (key_tr_ff <= 5'd25) &&
                     (key_bl_ff <= 5'd25) && (key_br_ff <= 5'd25) &&
                     det_in[0] && (det_in != 5'd13);
   end

   always_ff @(posedge clock) begin
      det_ff       <= det_in;
      key_valid_ff <= key_valid_in;
   end

   logic [4:0] m00_in, m01_in, m10_in, m11_in;
   logic [4:0] m00_ff, m01_ff, m10_ff, m11_ff;
   logic [4:0] det_inv, neg_tr, neg_bl;

   always_comb begin
      det_inv = unit_inverse(det_ff);
      neg_tr  = (key_tr_ff == 5'd0) ? 5'd0 : 5'(LETTER_MOD) - key_tr_ff;
      neg_bl  = (key_bl_ff == 5'd0) ? 5'd0 : 5'(LETTER_MOD) - key_bl_ff;
      if (decrypt_ff) begin
         m00_in = mod26(11'(key_br_ff) * 11'(det_inv));
         m01_in = mod26(11'(neg_tr) * 11'(det_inv));
         m10_in = mod26(11'(neg_bl) * 11'(det_inv));
         m11_in = mod26(11'(key_tl_ff) * 11'(det_inv));
      end else begin
         m00_in = key_tl_ff;
         m01_in = key_tr_ff;
         m10_in = key_bl_ff;
         m11_in = key_br_ff;
      end
   end

   always_ff @(posedge clock) begin
      m00_ff <= m00_in;
      m01_ff <= m01_in;
      m10_ff <= m10_in;
      m11_ff <= m11_in;
   end

   // pipeline control
   logic       s1_valid_ff, s2_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_fin_ff;
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       out_take, out_load, s2_free, s1_adv;

   assign out_take  = rsp_valid && !rsp_stall;
   assign out_load  = s2_valid_ff &&
                      ((out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && out_take));
   assign s2_free   = !s2_valid_ff || out_load;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_text_byte;
         s1_fin_ff  <= req_final_byte;
      end
   end

   // pairing stage
   logic [4:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   logic       is_upper, is_lower, is_letter;
   logic [4:0] letter;
   logic       s2_fill;
   logic       s2_err_in, s2_err_ff, s2_fin_in, s2_fin_ff;
   logic [4:0] s2_p1_in, s2_p1_ff, s2_p2_in, s2_p2_ff;

   always_comb begin
      is_upper  = (s1_byte_ff >= ASCII_UPPER_A) && (s1_byte_ff <= ASCII_UPPER_Z);
      is_lower  = (s1_byte_ff >= ASCII_LOWER_A) && (s1_byte_ff <= ASCII_LOWER_Z);
      is_letter = is_upper || is_lower;
      letter    = is_upper ? 5'(s1_byte_ff - ASCII_UPPER_A) : 5'(s1_byte_ff - ASCII_LOWER_A);
      s2_fill       = 1'b0;
      s2_err_in     = 1'b0;
      s2_fin_in     = s1_fin_ff;
      s2_p1_in      = held_ff;
      s2_p2_in      = letter;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      priority if (!key_valid_ff) begin
         s2_fill   = 1'b1;
         s2_err_in = 1'b1;
         if (s1_fin_ff) begin
            held_in       = 5'd0;
            held_valid_in = 1'b0;
         end
      end else if (is_letter && held_valid_ff) begin
         s2_fill       = 1'b1;
         held_in       = 5'd0;
         held_valid_in = 1'b0;
      end else if (is_letter && s1_fin_ff) begin
         s2_fill  = 1'b1;
         s2_p1_in = letter;
         s2_p2_in = PAD_LETTER;
         held_in  = 5'd0;
      end else if (is_letter) begin
         held_in       = letter;
         held_valid_in = 1'b1;
      end else if (s1_fin_ff && held_valid_ff) begin
         s2_fill       = 1'b1;
         s2_p2_in      = PAD_LETTER;
         held_in       = 5'd0;
         held_valid_in = 1'b0;
      end else begin
         s2_fill = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 5'd0;
         held_valid_ff <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (s1_adv) begin
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_adv && s2_fill;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_err_ff <= s2_err_in;
         s2_fin_ff <= s2_fin_in;
         s2_p1_ff  <= s2_p1_in;
         s2_p2_ff  <= s2_p2_in;
      end
   end

   // matrix stage into a two-word output buffer
   logic [4:0]   c1, c2;
   rsp_word_type word0, word1, slot0_ff, slot1_ff;

   always_comb begin
      c1 = mod26(11'(m00_ff) * 11'(s2_p1_ff) + 11'(m01_ff) * 11'(s2_p2_ff));
      c2 = mod26(11'(m10_ff) * 11'(s2_p1_ff) + 11'(m11_ff) * 11'(s2_p2_ff));
      if (s2_err_ff) begin
         word0 = '{cipher_char: 7'd0, last_in_run: 1'b1, end_of_text: s2_fin_ff,
                   key_error: 1'b1};
      end else begin
         word0 = '{cipher_char: CHAR_BASE + 7'(c1), last_in_run: 1'b0,
                   end_of_text: 1'b0, key_error: 1'b0};
      end
      word1 = '{cipher_char: CHAR_BASE + 7'(c2), last_in_run: 1'b1,
                end_of_text: s2_fin_ff, key_error: 1'b0};
   end

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (out_load) begin
         out_cnt_in = s2_err_ff ? 2'd1 : 2'd2;
      end else if (out_take) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         slot0_ff <= word0;
         slot1_ff <= word1;
      end else if (out_take) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_valid       = (out_cnt_ff != 2'd0);
   assign rsp_cipher_char = slot0_ff.cipher_char;
   assign rsp_last_in_run = slot0_ff.last_in_run;
   assign rsp_end_of_text = slot0_ff.end_of_text;
   assign rsp_key_error   = slot0_ff.key_error;

   property p_err_word;
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_error) |-> (rsp_last_in_run && rsp_cipher_char == 7'd0);
   endproperty
   a_err_word: assert property (p_err_word) else $error("bad error word");

   property p_letter_range;
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_error) |->
         (rsp_cipher_char >= CHAR_BASE && rsp_cipher_char <= 7'h5A);
   endproperty
   a_letter_range: assert property (p_letter_range) else $error("cipher char out of range");

   property p_end_is_last;
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_text) |-> rsp_last_in_run;
   endproperty
   a_end_is_last: assert property (p_end_is_last) else $error("end without last");

   property p_pair_second;
      @(posedge clock) disable iff (reset)
      (out_take && !rsp_last_in_run) |=> (rsp_valid && rsp_last_in_run);
   endproperty
   a_pair_second: assert property (p_pair_second) else $error("second pair word missing");

   property p_cnt_range;
      @(posedge clock) disable iff (reset)
      out_load |=> (out_cnt_ff == 2'd1 || out_cnt_ff == 2'd2);
   endproperty
   a_cnt_range: assert property (p_cnt_range) else $error("output buffer count");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import hc2s_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [4:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = '0;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_cipher_char;
   logic       rsp_last_in_run;
   logic       rsp_end_of_text;
   logic       rsp_key_error;

   hill_cipher_2x2_stream_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_char  (rsp_cipher_char),
      .rsp_last_in_run  (rsp_last_in_run),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_key_error    (rsp_key_error)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // cipher state mirror
   logic [4:0]   key_tl, key_tr, key_bl, key_br;
   logic         decrypt_on;
   logic [4:0]   held_char;
   bit           held_flag;
   rsp_word_type cipher_words[$];

   int unsigned mismatches = 0;
   int unsigned words_seen = 0;
   int          in_idle_pct = 24;
   int          out_idle_pct = 24;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   function automatic int det_mod26(input logic [4:0] tl, tr, bl, br);
      return (int'(tl) * int'(br) % 26 + 26 - int'(tr) * int'(bl) % 26) % 26;
   endfunction

   function automatic bit key_ok(input logic [4:0] tl, tr, bl, br);
      int d;
      if (tl > 25 || tr > 25 || bl > 25 || br > 25) begin
         return 1'b0;
      end
      d = det_mod26(tl, tr, bl, br);
      return (d % 2 == 1) && (d != 13);
   endfunction

   function automatic void push_word(input logic [6:0] ch, input bit last, input bit eot,
                                     input bit err);
      rsp_word_type w;
      w.cipher_char = ch;
      w.last_in_run = last;
      w.end_of_text = eot;
      w.key_error   = err;
      cipher_words.push_back(w);
   endfunction

   function automatic void push_pair(input int p1, input int p2, input bit eot);
      int m00 = key_tl;
      int m01 = key_tr;
      int m10 = key_bl;
      int m11 = key_br;
      int d;
      int dinv;
      if (decrypt_on) begin
         d = det_mod26(key_tl, key_tr, key_bl, key_br);
         dinv = 0;
         for (int x = 1; x < 26; x++) begin
            if (d * x % 26 == 1) begin
               dinv = x;
            end
         end
         m00 = int'(key_br) * dinv % 26;
         m01 = (26 - int'(key_tr)) % 26 * dinv % 26;
         m10 = (26 - int'(key_bl)) % 26 * dinv % 26;
         m11 = int'(key_tl) * dinv % 26;
      end
      push_word(CHAR_BASE + 7'((m00 * p1 + m01 * p2) % 26), 1'b0, 1'b0, 1'b0);
      push_word(CHAR_BASE + 7'((m10 * p1 + m11 * p2) % 26), 1'b1, eot, 1'b0);
   endfunction

   function automatic void predict_cipher(input logic [7:0] b, input bit fin);
      bit is_letter = 1'b0;
      int letter = 0;
      if (!key_ok(key_tl, key_tr, key_bl, key_br)) begin
         if (fin) begin
            held_flag = 1'b0;
            held_char = '0;
         end
         push_word('0, 1'b1, fin, 1'b1);
         return;
      end
      if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
         is_letter = 1'b1;
         letter = int'(b - ASCII_UPPER_A);
      end else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
         is_letter = 1'b1;
         letter = int'(b - ASCII_LOWER_A);
      end
      if (is_letter) begin
         if (held_flag) begin
            held_flag = 1'b0;
            push_pair(int'(held_char), letter, fin);
            held_char = '0;
         end else if (fin) begin
            held_char = '0;
            push_pair(letter, int'(PAD_LETTER), 1'b1);
         end else begin
            held_char = 5'(letter);
            held_flag = 1'b1;
         end
      end else if (fin && held_flag) begin
         held_flag = 1'b0;
         push_pair(int'(held_char), int'(PAD_LETTER), 1'b1);
         held_char = '0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH t=%0t: %s", $realtime, msg);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         words_seen++;
         if (cipher_words.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
         end else begin
            want = cipher_words.pop_front();
            if (rsp_cipher_char !== want.cipher_char) begin
               report_mismatch($sformatf("word %0d cipher_char got %0h want %0h",
                                         words_seen, rsp_cipher_char, want.cipher_char));
            end
            if (rsp_last_in_run !== want.last_in_run) begin
               report_mismatch($sformatf("word %0d last_in_run got %b want %b",
                                         words_seen, rsp_last_in_run, want.last_in_run));
            end
            if (rsp_end_of_text !== want.end_of_text) begin
               report_mismatch($sformatf("word %0d end_of_text got %b want %b",
                                         words_seen, rsp_end_of_text, want.end_of_text));
            end
            if (rsp_key_error !== want.key_error) begin
               report_mismatch($sformatf("word %0d key_error got %b want %b",
                                         words_seen, rsp_key_error, want.key_error));
            end
         end
      end
   end

   // receiver stall, with a long hold on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < out_idle_pct);
      end
   end

   initial begin : watchdog
      int unsigned n;
      for (n = 0; n < CYCLE_LIMIT; n++) begin
         @(posedge clock);
      end
      $display("hill_cipher_2x2_stream_top regression: fail");
      $finish;
   end

   // called and returns at a rising edge
   task automatic send_word(input logic [7:0] b, input bit fin);
      while ($urandom_range(99) < in_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_final_byte <= fin;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_cipher(b, fin);
   endtask

   task automatic send_string(input string s, input bit fin_last);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], fin_last && (i == s.len() - 1));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cipher_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [4:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_KEY_TL:  key_tl = data;
         CSR_KEY_TR:  key_tr = data;
         CSR_KEY_BL:  key_bl = data;
         CSR_KEY_BR:  key_br = data;
         CSR_DECRYPT: decrypt_on = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [4:0] tl, tr, bl, br, input logic dec);
      wait_idle();
      csr_write(CSR_KEY_TL, tl);
      csr_write(CSR_KEY_TR, tr);
      csr_write(CSR_KEY_BL, bl);
      csr_write(CSR_KEY_BR, br);
      csr_write(CSR_DECRYPT, {4'($urandom_range(15)), dec});
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_text(input int n);
      int sent = 0;
      int len;
      logic [7:0] b;
      while (sent < n) begin
         if ($urandom_range(9) < 8) begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 85) begin
                  b = ($urandom_range(1) ? ASCII_UPPER_A : ASCII_LOWER_A) +
                      8'($urandom_range(25));
               end else begin
                  b = 8'($urandom_range(32, 64));
               end
               send_word(b, i == len - 1);
            end
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
            end
         end
         sent += len;
      end
   endtask

   task automatic test_reset_key();
      send_string("AZ", 1'b0);
      send_string("az", 1'b0);
      send_string("mQ", 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h80, 1'b0);
      send_string("@[`{", 1'b0);
      send_word(".", 1'b1);
      send_word("K", 1'b0);
      send_word(8'hFF, 1'b1);
      send_string("Bz", 1'b1);
      send_word("q", 1'b1);
      wait_idle();
   endtask

   task automatic test_decrypt();
      set_config(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
      send_string("Hi!", 1'b1);
      set_config(5'd25, 5'd0, 5'd0, 5'd25, 1'b1);
      send_string("ZAaz", 1'b0);
      wait_idle();
   endtask

   task automatic test_bad_key();
      set_config(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
      send_word("G", 1'b0);
      set_config(5'd31, 5'd3, 5'd2, 5'd5, 1'b0);
      send_word("A", 1'b0);
      set_config(5'd2, 5'd0, 5'd0, 5'd1, 1'b0);
      send_word("b", 1'b0);
      set_config(5'd13, 5'd0, 5'd0, 5'd1, 1'b1);
      send_word("c", 1'b0);
      set_config(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
      send_string("HD", 1'b0);
      set_config(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
      send_word(" ", 1'b1);
      set_config(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
      send_word("E", 1'b1);
      wait_idle();
   endtask

   // indexes past the list must not disturb the key
   task automatic test_unused_index();
      wait_idle();
      for (int i = int'(CSR_DECRYPT) + 1; i < 8; i++) begin
         csr_write(3'(i), (i % 2 == 1) ? 5'h1F : 5'h00);
      end
      csr_write(CSR_DECRYPT, 5'b11110);
      csr_write_enable <= 1'b0;
      send_string("QR", 1'b0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_requests++;
      send_random_text(80);
      wait_idle();
   endtask

   task automatic test_no_gaps();
      in_idle_pct = 0;
      out_idle_pct = 0;
      send_random_text(200);
      wait_idle();
      in_idle_pct = 24;
      out_idle_pct = 24;
   endtask

   task automatic test_random_keys();
      logic [4:0] a, b, c, d;
      bit need_ok;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_config(5'd25, 5'd0, 5'd0, 5'd25, 1'b0);
            1: set_config(5'd0, 5'd25, 5'd25, 5'd0, 1'b1);
            2: set_config(5'($urandom_range(26, 31)), 5'($urandom_range(31)),
                          5'($urandom_range(31)), 5'($urandom_range(26, 31)),
                          1'($urandom_range(1)));
            default: begin
               need_ok = ($urandom_range(4) != 0);
               do begin
                  a = 5'($urandom_range(need_ok ? 25 : 31));
                  b = 5'($urandom_range(need_ok ? 25 : 31));
                  c = 5'($urandom_range(need_ok ? 25 : 31));
                  d = 5'($urandom_range(need_ok ? 25 : 31));
               end while (need_ok && !key_ok(a, b, c, d));
               set_config(a, b, c, d, 1'($urandom_range(1)));
            end
         endcase
         send_random_text(170);
         wait_idle();
      end
   endtask

   initial begin
      key_tl     = KEY_TL_RESET;
      key_tr     = KEY_TR_RESET;
      key_bl     = KEY_BL_RESET;
      key_br     = KEY_BR_RESET;
      decrypt_on = 1'b0;
      held_char  = '0;
      held_flag  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_decrypt();
      test_bad_key();
      test_unused_index();
      test_backpressure();
      test_no_gaps();
      test_random_keys();
      wait_idle();
      if (mismatches == 0) begin
         $display("hill_cipher_2x2_stream_top regression: pass");
      end else begin
         $display("hill_cipher_2x2_stream_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- hill_cipher_2x2_stream_top.f -----
rtl/hc2s_pkg.sv
rtl/hill_cipher_2x2_stream_top.sv
tb/testbench.sv
